FILE: src/plc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plc_pkg - shared types and codes for the positional list block
// Holds the result status codes, the request kinds and the sequencer state type.
// ----------------------------------------------------------------------------
package plc_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } plc_status_t;

  // Request kinds.
  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_DELETE = 1'b1
  } plc_kind_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DEL_CAP,
    S_SH_RD,
    S_SH_WR,
    S_INS_WR,
    S_RESP
  } plc_state_t;

endpackage : plc_pkg
`default_nettype wire

FILE: src/plc_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plc_req_if - request channel of the positional list
// Carries one insert or delete request per beat under valid/ready.
// ----------------------------------------------------------------------------
interface plc_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  position;
  logic signed [31:0] value;

  modport source (output valid, output kind, output position, output value, input ready);
  modport sink   (input valid, input kind, input position, input value, output ready);
endinterface : plc_req_if
`default_nettype wire

FILE: src/plc_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plc_rsp_if - result channel of the positional list
// Carries one result per beat under valid/ready.
// ----------------------------------------------------------------------------
interface plc_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [31:0] removed_value;
  logic [7:0]  new_length;

  modport source (output valid, output status, output removed_value, output new_length,
                  input ready);
  modport sink   (input valid, input status, input removed_value, input new_length,
                  output ready);
endinterface : plc_rsp_if
`default_nettype wire

FILE: src/plc_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plc_mem - entry storage
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module plc_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : plc_mem
`default_nettype wire

FILE: src/plc_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plc_seq - request sequencer
// Checks each request, then moves entries one at a time through the storage
// using a single shared pointer step unit, and keeps the entry count.
// ----------------------------------------------------------------------------
module plc_seq
  import plc_pkg::*;
#(
  parameter int CAPACITY = 128,
  parameter int AW       = 7,
  parameter int CW       = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  // request side
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire logic          req_kind,
  input  wire logic [7:0]    req_position,
  input  wire logic [31:0]   req_value,
  // result side
  input  wire logic          res_free,
  output logic               res_valid,
  output logic [1:0]         res_status,
  output logic [31:0]        res_removed,
  output logic [7:0]         res_length,
  // storage port
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [31:0]        mem_wdata,
  output logic [AW-1:0]      mem_raddr,
  input  wire logic [31:0]   mem_rdata
);

  localparam int CMPW = ((CW > 8) ? CW : 8) + 1;

  plc_state_t  state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;
  logic [AW-1:0] idx;
  logic          op_kind;
  logic [31:0]   op_value;
  plc_status_t   op_status;
  logic [31:0]   removed;

  logic [CMPW-1:0] pos_w, cnt_w, idx_full;
  logic [AW-1:0]   idx_in;
  plc_status_t     chk_status;
  logic [CW-1:0]   ptr_inc, ptr_dec;
  logic [CW-1:0]   count_after;
  logic [CW+7:0]   length_ext;
  logic            accept;

  assign accept = (state == S_IDLE) && req_valid;

  // Request check.
  always_comb begin
    pos_w    = CMPW'(req_position);
    cnt_w    = CMPW'(count);
    idx_full = pos_w - CMPW'(1);
    idx_in   = idx_full[AW-1:0];
    if (req_kind == KIND_INSERT) begin
      if (pos_w == '0 || pos_w > cnt_w + CMPW'(1)) begin
        chk_status = ST_RANGE;
      end else if (count == CW'(CAPACITY)) begin
        chk_status = ST_FULL;
      end else begin
        chk_status = ST_DONE;
      end
    end else begin
      if (pos_w == '0 || pos_w > cnt_w) begin
        chk_status = ST_RANGE;
      end else begin
        chk_status = ST_DONE;
      end
    end
  end

  // Shared pointer step unit.
  assign ptr_inc = ptr + CW'(1);
  assign ptr_dec = ptr - CW'(1);

  always_comb begin
    if (op_status != ST_DONE) begin
      count_after = count;
    end else if (op_kind == KIND_DELETE) begin
      count_after = count - CW'(1);
    end else begin
      count_after = count + CW'(1);
    end
  end

  assign length_ext = {8'd0, count_after};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (chk_status != ST_DONE) begin
            state_next = S_RESP;
          end else if (req_kind == KIND_DELETE) begin
            state_next = S_DEL_CAP;
          end else if (count == CW'(idx_in)) begin
            state_next = S_INS_WR;
          end else begin
            state_next = S_SH_RD;
          end
        end
      end
      S_DEL_CAP: begin
        state_next = (ptr == count) ? S_RESP : S_SH_RD;
      end
      S_SH_RD: begin
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        if (op_kind == KIND_DELETE) begin
          state_next = (ptr_inc == count) ? S_RESP : S_SH_RD;
        end else begin
          state_next = (ptr_dec == CW'(idx)) ? S_INS_WR : S_SH_RD;
        end
      end
      S_INS_WR: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    req_ready = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = ptr[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = ptr[AW-1:0];
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        mem_raddr = idx_in;
      end
      S_SH_RD: begin
        mem_raddr = (op_kind == KIND_DELETE) ? ptr[AW-1:0] : ptr_dec[AW-1:0];
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = (op_kind == KIND_DELETE) ? ptr_dec[AW-1:0] : ptr[AW-1:0];
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = op_value;
      end
      S_RESP: begin
        res_valid = 1'b1;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  assign res_status  = op_status;
  assign res_removed = removed;
  assign res_length  = length_ext[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_RESP && res_free) begin
        count <= count_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind   <= req_kind;
      op_value  <= req_value;
      op_status <= chk_status;
      idx       <= idx_in;
      removed   <= '0;
      ptr       <= (req_kind == KIND_DELETE) ? CW'(idx_in) + CW'(1) : count;
    end else if (state == S_DEL_CAP) begin
      removed <= mem_rdata;
    end else if (state == S_SH_WR) begin
      ptr <= (op_kind == KIND_DELETE) ? ptr_inc : ptr_dec;
    end
  end

endmodule : plc_seq
`default_nettype wire

FILE: src/positional_list_insert_delete.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_insert_delete - ordered list with positional insert/delete
// Top level: sequencer, entry storage and the result register.
// ----------------------------------------------------------------------------
// The block holds an ordered list of up to CAPACITY signed 32-bit entries.
// A request beat either inserts a value before a 1-based position or deletes
// the entry at a position, and every request gives exactly one result beat
// with a status, the removed entry (zero unless a delete succeeded) and the
// new length, reported as the low eight bits of the count. A bad position or
// an insert into a full list is rejected and leaves the list untouched; when
// both faults apply the range fault is reported. Entries live in a memory with
// one write port and one registered read port, and later entries are moved one
// at a time, each move passing through a read state and then a write state.
// An insert moves the entries from its position onward up one place, last
// first, then writes the new value; a delete captures the entry and moves
// the later ones down. A rejected request moves nothing; a new request is taken
// only once the previous one has been handed to the result register. The
// result register lets a finished result wait for the consumer while the next
// request is accepted. No clearing pass runs after reset: entries are read
// only after they have been written.
// ----------------------------------------------------------------------------
module positional_list_insert_delete
  import plc_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  wire logic clk,
  input  wire logic rst,
  plc_req_if.sink   req,
  plc_rsp_if.source rsp
);

  // Address width for the storage and width of the entry count, which must
  // be able to hold CAPACITY itself.
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic          res_valid;
  logic [1:0]    res_status;
  logic [31:0]   res_removed;
  logic [7:0]    res_length;
  logic          res_free;
  logic          res_load;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  // Result register state.
  logic          out_valid;
  logic [1:0]    out_status;
  logic [31:0]   out_removed;
  logic [7:0]    out_length;

  // The result register can take a new beat when it is empty or when its
  // current beat is being taken in this cycle.
  assign res_free = !out_valid || rsp.ready;
  assign res_load = res_valid && res_free;

  plc_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_kind     (req.kind),
    .req_position (req.position),
    .req_value    (req.value),
    .res_free     (res_free),
    .res_valid    (res_valid),
    .res_status   (res_status),
    .res_removed  (res_removed),
    .res_length   (res_length),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  plc_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The valid flag is control state and is cleared by reset; the payload
  // is simply loaded alongside it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status  <= res_status;
      out_removed <= res_removed;
      out_length  <= res_length;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.removed_value = out_removed;
  assign rsp.new_length    = out_length;

`ifndef SYNTH
  // A loaded result is presented in the following cycle.
  a_load_presents: assert property (@(posedge clk) disable iff (rst)
    res_load |=> rsp.valid)
    else $error("result loaded but not presented");

  // Only a successful delete may return a non-zero removed entry.
  a_removed_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_DONE) |-> (rsp.removed_value == '0))
    else $error("removed value non-zero on a rejected request");

  // A full status can only be reported with the list at capacity.
  a_full_length: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_FULL) |-> (rsp.new_length == 8'(CAPACITY)))
    else $error("full status reported below capacity");

  // Every request keeps the sequencer busy, so request beats are never accepted back to back.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted in back-to-back cycles");
`endif

endmodule : positional_list_insert_delete
`default_nettype wire

FILE: tb/sv/positional_list_insert_delete_tb.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete_tb - self-checking bench for the list block
// Drives insert and delete request beats with random pacing on both channels,
// predicts every result from a shadow copy of the list and compares each
// result beat field by field, in order, against the predicted or typed one.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_tb;
  import plc_pkg::*;

  localparam int LIST_CAPACITY   = 128;
  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 7;
  localparam int TARGET_REQUESTS = 1300;
  localparam int DIRECTED_ROWS   = 23;
  // The slowest request shifts a whole list, so the settle wait scales with LIST_CAPACITY.
  localparam int SETTLE_CYCLES   = 2 * LIST_CAPACITY + 16;
  localparam int LONG_HOLD       = 400;
  localparam int HOLD_AFTER_REQS = 500;
  localparam int WATCHDOG_CYCLES = 3_000_000;

  typedef struct packed {
    plc_status_t        status;
    logic signed [31:0] removed;
    logic [7:0]         length;
  } list_result_t;

  // One row of the directed sequence. Where known is set, the result is typed
  // in by hand; otherwise the shadow list supplies it.
  typedef struct {
    plc_kind_t          kind;
    logic [7:0]         position;
    logic signed [31:0] value;
    bit                 known;
    list_result_t       result;
  } stim_row_t;

  logic clk;
  logic rst;

  plc_req_if req_bus ();
  plc_rsp_if rsp_bus ();

  positional_list_insert_delete #(
    .CAPACITY(LIST_CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  // Shadow of the list held inside the block, updated on every accepted
  // request beat, and the results that are still owed by the block.
  logic signed [31:0] shadow_list [LIST_CAPACITY];
  int                 shadow_len;
  list_result_t       pending_results [$];

  int error_count;
  int requests_accepted;
  int results_checked;
  int inserts_done;
  int deletes_done;
  int range_rejects;
  int full_rejects;
  int full_hits;
  int peak_length;

  // Sender pacing: the number of beats left in the current burst.
  int burst_left;

  // The directed opening. It starts from an empty list, walks both kinds
  // through the position limits and both value extremes, and checks that a
  // rejected request leaves zero in the removed field and the length alone.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // Delete from an empty list, and inserts before an impossible position.
    '{KIND_DELETE, 8'd1,   32'sd0,          1'b1, '{ST_RANGE, 32'sd0, 8'd0}},
    '{KIND_INSERT, 8'd0,   32'sd5,          1'b1, '{ST_RANGE, 32'sd0, 8'd0}},
    '{KIND_INSERT, 8'd2,   32'sd5,          1'b1, '{ST_RANGE, 32'sd0, 8'd0}},
    // Build the list [-1, max, min].
    '{KIND_INSERT, 8'd1,   32'sh7FFF_FFFF,  1'b1, '{ST_DONE,  32'sd0, 8'd1}},
    '{KIND_INSERT, 8'd2,   32'sh8000_0000,  1'b1, '{ST_DONE,  32'sd0, 8'd2}},
    '{KIND_INSERT, 8'd1,   -32'sd1,         1'b1, '{ST_DONE,  32'sd0, 8'd3}},
    // Out of range at the high end for inserts and at both ends for deletes.
    '{KIND_INSERT, 8'd255, 32'sd0,          1'b1, '{ST_RANGE, 32'sd0, 8'd3}},
    '{KIND_DELETE, 8'd0,   32'sd0,          1'b1, '{ST_RANGE, 32'sd0, 8'd3}},
    '{KIND_DELETE, 8'd4,   32'sd0,          1'b1, '{ST_RANGE, 32'sd0, 8'd3}},
    '{KIND_DELETE, 8'd255, 32'sd0,          1'b1, '{ST_RANGE, 32'sd0, 8'd3}},
    // Append one past the end, then insert in the middle.
    '{KIND_INSERT, 8'd4,   32'sd0,          1'b1, '{ST_DONE,  32'sd0, 8'd4}},
    '{KIND_INSERT, 8'd3,   32'sh5A5A_A5A5,  1'b0, '0},
    // Delete with a non-zero value field, which the block must ignore.
    '{KIND_DELETE, 8'd2,   32'sh1234_5678,  1'b1, '{ST_DONE, 32'sh7FFF_FFFF, 8'd4}},
    '{KIND_DELETE, 8'd4,   32'sd0,          1'b0, '0},
    '{KIND_DELETE, 8'd3,   32'sd0,          1'b0, '0},
    '{KIND_INSERT, 8'd2,   32'sd1,          1'b0, '0},
    '{KIND_DELETE, 8'd1,   -32'sd1,         1'b0, '0},
    '{KIND_DELETE, 8'd1,   32'sd0,          1'b0, '0},
    '{KIND_DELETE, 8'd1,   32'sd0,          1'b0, '0},
    // Empty again: delete fails, then a single entry comes and goes.
    '{KIND_DELETE, 8'd1,   32'sd0,          1'b1, '{ST_RANGE, 32'sd0, 8'd0}},
    '{KIND_INSERT, 8'd1,   32'sd0,          1'b1, '{ST_DONE,  32'sd0, 8'd1}},
    '{KIND_DELETE, 8'd128, 32'sd0,          1'b1, '{ST_RANGE, 32'sd0, 8'd1}},
    '{KIND_DELETE, 8'd1,   32'sd0,          1'b1, '{ST_DONE,  32'sd0, 8'd0}}
  };

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Applies one request to the shadow list and returns the result the block
  // owes for it. A rejected request leaves the shadow list untouched; when an
  // insert is both out of range and aimed at a full list, range wins.
  function automatic list_result_t predict_list_op(plc_kind_t kind,
                                                   logic [7:0] position,
                                                   logic signed [31:0] value);
    list_result_t res;
    int           pos;
    int           i;
    pos         = int'(position);
    res.status  = ST_DONE;
    res.removed = '0;
    if (kind == KIND_INSERT) begin
      if (pos < 1 || pos > shadow_len + 1) begin
        res.status = ST_RANGE;
      end else if (shadow_len >= LIST_CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        for (i = shadow_len; i > pos - 1; i--) shadow_list[i] = shadow_list[i - 1];
        shadow_list[pos - 1] = value;
        shadow_len++;
      end
    end else begin
      if (pos < 1 || pos > shadow_len) begin
        res.status = ST_RANGE;
      end else begin
        res.removed = shadow_list[pos - 1];
        for (i = pos; i < shadow_len; i++) shadow_list[i - 1] = shadow_list[i];
        shadow_len--;
      end
    end
    res.length = shadow_len[7:0];

    // Tallies for the closing summary.
    case (res.status)
      ST_RANGE: range_rejects++;
      ST_FULL:  full_rejects++;
      default: begin
        if (kind == KIND_INSERT) inserts_done++;
        else deletes_done++;
      end
    endcase
    if (kind == KIND_INSERT && res.status == ST_DONE && shadow_len == LIST_CAPACITY)
      full_hits++;
    if (shadow_len > peak_length) peak_length = shadow_len;
    return res;
  endfunction

  // Values lean towards the extremes and the patterns around zero.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Offers one request beat and waits until the block takes it. Bursts of
  // back-to-back beats are separated by random gaps, some of them zero so that
  // long unbroken stretches occur too. Once the beat is taken, the shadow list
  // is advanced and the owed result is queued; a typed result from the
  // directed rows takes the place of the predicted one.
  task automatic offer_request(input plc_kind_t kind, input logic [7:0] position,
                               input logic signed [31:0] value, input bit known,
                               input list_result_t typed_result);
    int           gap;
    list_result_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        9:       gap = $urandom_range(10, 40);
        default: gap = $urandom_range(1, 5);
      endcase
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;

    req_bus.valid    <= 1'b1;
    req_bus.kind     <= kind;
    req_bus.position <= position;
    req_bus.value    <= value;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);

    requests_accepted++;
    predicted = predict_list_op(kind, position, value);
    pending_results.push_back(known ? typed_result : predicted);
  endtask

  task automatic offer_random(input plc_kind_t kind, input logic [7:0] position);
    offer_request(kind, position, pick_value(), 1'b0, '0);
  endtask

  // Everyday traffic on a short list: mostly valid positions, with some
  // positions just past either end and some pure noise over the whole field.
  task automatic churn_request();
    int roll;
    int insert_odds;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      offer_random(plc_kind_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end else if (roll < 14) begin
      case ($urandom_range(0, 2))
        0:       offer_random(KIND_DELETE, 8'(shadow_len + 1));
        1:       offer_random(KIND_INSERT, 8'(shadow_len + 2));
        default: offer_random(plc_kind_t'($urandom_range(0, 1)), 8'd0);
      endcase
    end else begin
      // Keep the list short most of the time so that shifts stay cheap.
      if (shadow_len < 8) insert_odds = 70;
      else if (shadow_len > 40) insert_odds = 30;
      else insert_odds = 50;
      if (shadow_len == 0 || $urandom_range(0, 99) < insert_odds) begin
        case ($urandom_range(0, 5))
          0:       offer_random(KIND_INSERT, 8'd1);
          1:       offer_random(KIND_INSERT, 8'(shadow_len + 1));
          default: offer_random(KIND_INSERT, 8'($urandom_range(1, shadow_len + 1)));
        endcase
      end else begin
        case ($urandom_range(0, 5))
          0:       offer_random(KIND_DELETE, 8'd1);
          1:       offer_random(KIND_DELETE, 8'(shadow_len));
          default: offer_random(KIND_DELETE, 8'($urandom_range(1, shadow_len)));
        endcase
      end
    end
  endtask

  // Fills the list to capacity, probes the full list from every side, then
  // empties it completely and probes the empty list.
  task automatic fill_and_drain();
    while (shadow_len < LIST_CAPACITY)
      offer_random(KIND_INSERT, 8'($urandom_range(1, shadow_len + 1)));
    offer_random(KIND_INSERT, 8'($urandom_range(1, LIST_CAPACITY)));
    offer_random(KIND_INSERT, 8'(LIST_CAPACITY + 1));
    offer_random(KIND_INSERT, 8'($urandom_range(LIST_CAPACITY + 2, 255)));
    offer_random(KIND_INSERT, 8'd0);
    offer_random(KIND_DELETE, 8'(LIST_CAPACITY + 1));
    offer_random(KIND_DELETE, 8'(LIST_CAPACITY));
    offer_random(KIND_INSERT, 8'(LIST_CAPACITY));
    offer_random(KIND_DELETE, 8'd1);
    while (shadow_len > 0) begin
      if ($urandom_range(0, 3) == 0) offer_random(KIND_DELETE, 8'd1);
      else offer_random(KIND_DELETE, 8'($urandom_range(1, shadow_len)));
    end
    offer_random(KIND_DELETE, 8'd1);
  endtask

  // Result side. Each accepted result beat is compared with the oldest owed
  // result. The ready line follows a pattern of its own: stretches of always
  // ready, random stalls, a regular stall, and mostly stalled, plus one long
  // hold-off once enough requests have gone in, so that the result register
  // stays occupied and the block has to refuse further request beats.
  initial begin
    int           mode;
    int           seg_left;
    int           hold_left;
    int           phase;
    bit           long_hold_done;
    list_result_t want;
    mode           = 0;
    seg_left       = 0;
    hold_left      = 0;
    phase          = 0;
    long_hold_done = 1'b0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_bus.valid && rsp_bus.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing owed: status %0d removed %0d length %0d",
                   $time, rsp_bus.status, rsp_bus.removed_value, rsp_bus.new_length);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (rsp_bus.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d got %0d",
                     $time, want.status, rsp_bus.status);
            error_count++;
          end
          if (rsp_bus.removed_value !== want.removed) begin
            $display("%0t: removed value mismatch, expected %0d got %0d",
                     $time, want.removed, rsp_bus.removed_value);
            error_count++;
          end
          if (rsp_bus.new_length !== want.length) begin
            $display("%0t: length mismatch, expected %0d got %0d",
                     $time, want.length, rsp_bus.new_length);
            error_count++;
          end
        end
      end

      phase++;
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (!long_hold_done && requests_accepted >= HOLD_AFTER_REQS) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        case (mode)
          0:       rsp_bus.ready <= 1'b1;
          1:       rsp_bus.ready <= ($urandom_range(0, 9) < 6);
          2:       rsp_bus.ready <= (phase % 4 != 0);
          default: rsp_bus.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Main sequence: reset, directed rows, random traffic with two full
  // fill-and-drain rounds placed inside it, then wait for the tail.
  initial begin
    int fill_rounds;
    error_count       = 0;
    requests_accepted = 0;
    results_checked   = 0;
    inserts_done      = 0;
    deletes_done      = 0;
    range_rejects     = 0;
    full_rejects      = 0;
    full_hits         = 0;
    peak_length       = 0;
    burst_left        = 0;
    shadow_len        = 0;
    fill_rounds       = 0;

    rst              <= 1'b1;
    req_bus.valid    <= 1'b0;
    req_bus.kind     <= KIND_INSERT;
    req_bus.position <= '0;
    req_bus.value    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      offer_request(directed_rows[r].kind, directed_rows[r].position,
                    directed_rows[r].value, directed_rows[r].known,
                    directed_rows[r].result);

    while (requests_accepted < TARGET_REQUESTS) begin
      if (fill_rounds < 2 && requests_accepted >= 350 + fill_rounds * 450) begin
        fill_and_drain();
        fill_rounds++;
      end else begin
        churn_request();
      end
    end
    req_bus.valid <= 1'b0;

    // Every owed result must arrive; after that, stay a while in case the
    // block produces anything it was not asked for.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Requests: %0d inserts and %0d deletes done, %0d range and %0d full rejections.",
             inserts_done, deletes_done, range_rejects, full_rejects);
    $display("List peaked at %0d entries, filled %0d times; %0d result beats checked.",
             peak_length, full_hits, results_checked);
    if (error_count == 0) begin
      $display("positional_list_insert_delete verification clean");
    end else begin
      $display("positional_list_insert_delete verification failed");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(CLK_PERIOD * WATCHDOG_CYCLES);
    $display("positional_list_insert_delete verification failed");
    $finish;
  end

endmodule : positional_list_insert_delete_tb

FILE: sim.f
src/plc_pkg.sv
src/plc_req_if.sv
src/plc_rsp_if.sv
src/plc_mem.sv
src/plc_seq.sv
src/positional_list_insert_delete.sv
tb/sv/positional_list_insert_delete_tb.sv
